>>> rtl/tvsd_pkg.sv
// Types and constants shared by the tagged value stream decoder.
// No dependencies; the parser, formatter, result buffer and top level refer to this package.
package tvsd_pkg;

    // Parser phase
    typedef enum logic [2:0] {
        PH_TAG       = 3'd0,
        PH_EXT_TAG   = 3'd1,
        PH_LEN_MARK  = 3'd2,
        PH_LEN_BYTES = 3'd3,
        PH_CONTENT   = 3'd4,
        PH_SKIP      = 3'd5
    } phase_t;

    // Outcome of one byte
    typedef enum logic [1:0] {
        RES_NONE  = 2'd0,
        RES_DONE  = 2'd1,
        RES_ERROR = 2'd2
    } step_res_t;

    // Application tag numbers
    localparam logic [3:0] TAG_NULL         = 4'd0;
    localparam logic [3:0] TAG_BOOLEAN      = 4'd1;
    localparam logic [3:0] TAG_UNSIGNED     = 4'd2;
    localparam logic [3:0] TAG_SIGNED       = 4'd3;
    localparam logic [3:0] TAG_REAL         = 4'd4;
    localparam logic [3:0] TAG_DOUBLE       = 4'd5;
    localparam logic [3:0] TAG_OCTET_STRING = 4'd6;
    localparam logic [3:0] TAG_CHAR_STRING  = 4'd7;
    localparam logic [3:0] TAG_BIT_STRING   = 4'd8;
    localparam logic [3:0] TAG_ENUMERATED   = 4'd9;
    localparam logic [3:0] TAG_DATE         = 4'd10;
    localparam logic [3:0] TAG_TIME         = 4'd11;
    localparam logic [3:0] TAG_OBJECT_ID    = 4'd12;
    localparam logic [3:0] TAG_EXTENDED     = 4'd15;

    // Tag octet layout and length encodings
    localparam int         CLASS_BIT      = 3;
    localparam logic [2:0] RAW_LEN_EXT    = 3'd5;
    localparam logic [7:0] LEN_MARK_16    = 8'd254;
    localparam logic [7:0] LEN_MARK_32    = 8'd255;
    localparam logic [2:0] EXT_BYTES_16   = 3'd2;
    localparam logic [2:0] EXT_BYTES_32   = 3'd4;

    localparam logic [7:0]  MAX_UNUSED_BITS = 8'd7;
    localparam logic [7:0]  YEAR_UNSPEC     = 8'd255;
    localparam logic [11:0] YEAR_BASE       = 12'd1900;
    localparam logic [21:0] INSTANCE_MASK   = 22'h3FFFFF;

    // Parser state at the point a result is due
    typedef struct packed {
        logic        err;
        logic [3:0]  tag;
        logic [2:0]  raw_len;
        logic [2:0]  hdr;
        logic [31:0] len;
        logic [31:0] acc;
        logic [7:0]  fcb;
    } raw_result_t;

    typedef struct packed {
        logic        status;
        logic [3:0]  value_type;
        logic [32:0] consumed_bytes;
        logic [31:0] word_value;
        logic [9:0]  object_type;
        logic [21:0] object_instance;
        logic [11:0] date_year;
        logic        year_unspecified;
        logic [2:0]  data_offset;
        logic [31:0] data_length;
        logic [7:0]  charset;
        logic [34:0] bit_count;
    } result_t;

    // Content length permitted for a tag
    function automatic logic length_ok(logic [3:0] tag, logic [31:0] len);
        logic ok;
        ok = 1'b1;
        case (tag)
            TAG_UNSIGNED, TAG_SIGNED, TAG_ENUMERATED:
                ok = (len >= 32'd1) && (len <= 32'd4);
            TAG_REAL, TAG_DATE, TAG_TIME, TAG_OBJECT_ID:
                ok = (len == 32'd4);
            TAG_CHAR_STRING, TAG_BIT_STRING:
                ok = (len != 32'd0);
            default:
                ok = 1'b1;
        endcase
        return ok;
    endfunction

endpackage

>>> rtl/tvsd_in_if.sv
// Byte stream channel of the tagged value decoder: valid/ready plus one byte and a last-byte flag.
// No dependencies.
interface tvsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

>>> rtl/tvsd_out_if.sv
// Result channel of the tagged value decoder: valid/ready plus decoded fields.
// No dependencies.
interface tvsd_out_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic [3:0]  value_type;
    logic [32:0] consumed_bytes;
    logic [31:0] word_value;
    logic [9:0]  object_type;
    logic [21:0] object_instance;
    logic [11:0] date_year;
    logic        year_unspecified;
    logic [2:0]  data_offset;
    logic [31:0] data_length;
    logic [7:0]  charset;
    logic [34:0] bit_count;

    modport source (
        output valid, input ready,
        output status, output value_type, output consumed_bytes, output word_value,
        output object_type, output object_instance, output date_year,
        output year_unspecified, output data_offset, output data_length,
        output charset, output bit_count
    );
    modport sink (
        input valid, output ready,
        input status, input value_type, input consumed_bytes, input word_value,
        input object_type, input object_instance, input date_year,
        input year_unspecified, input data_offset, input data_length,
        input charset, input bit_count
    );
endinterface

>>> rtl/tvsd_parser.sv
// Per-byte tag/length/content parser of the tagged value decoder.
// Depends on tvsd_pkg.
module tvsd_parser #(
    parameter int LENGTH_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic [7:0]            data_byte,
    input  logic                  last_byte,
    output logic                  emit,
    output tvsd_pkg::raw_result_t raw_res
);

    tvsd_pkg::phase_t    phase_reg, phase_next, step_phase;
    tvsd_pkg::step_res_t step_res;

    logic [3:0]             tag_number_reg, tag_number_next;
    logic [2:0]             raw_length_bits_reg, raw_length_bits_next;
    logic [2:0]             header_count_reg, header_count_next;
    logic [2:0]             ext_bytes_left_reg, ext_bytes_left_next;
    logic [LENGTH_BITS-1:0] content_length_reg, content_length_next;
    logic [LENGTH_BITS-1:0] content_count_reg, content_count_next;
    logic [31:0]            accumulator_reg, accumulator_next;
    logic [7:0]             first_content_byte_reg, first_content_byte_next;

    logic                   tag_known;
    logic                   len_known;
    logic [31:0]            len_cand;
    logic [31:0]            acc_shift;
    logic [LENGTH_BITS:0]   count_inc;

    // Byte decode and data path
    always_comb
    begin
        tag_number_next         = tag_number_reg;
        raw_length_bits_next    = raw_length_bits_reg;
        header_count_next       = header_count_reg;
        ext_bytes_left_next     = ext_bytes_left_reg;
        content_length_next     = content_length_reg;
        content_count_next      = content_count_reg;
        accumulator_next        = accumulator_reg;
        first_content_byte_next = first_content_byte_reg;
        step_res   = tvsd_pkg::RES_NONE;
        step_phase = phase_reg;
        tag_known  = 1'b0;
        len_known  = 1'b0;
        len_cand   = 32'd0;
        acc_shift  = {accumulator_reg[23:0], data_byte};
        count_inc  = {1'b0, content_count_reg} + (LENGTH_BITS+1)'(1);

        case (phase_reg)
            tvsd_pkg::PH_TAG:
            begin
                tag_number_next         = data_byte[7:4];
                raw_length_bits_next    = data_byte[2:0];
                header_count_next       = 3'd1;
                ext_bytes_left_next     = 3'd0;
                content_length_next     = '0;
                content_count_next      = '0;
                accumulator_next        = 32'd0;
                first_content_byte_next = 8'd0;
                if (data_byte[tvsd_pkg::CLASS_BIT] || data_byte[2:0] > tvsd_pkg::RAW_LEN_EXT)
                    step_res = tvsd_pkg::RES_ERROR;
                else if (data_byte[7:4] == tvsd_pkg::TAG_EXTENDED)
                    step_phase = tvsd_pkg::PH_EXT_TAG;
                else
                    tag_known = 1'b1;
            end
            tvsd_pkg::PH_EXT_TAG:
            begin
                header_count_next = 3'd2;
                if (data_byte >= 8'(tvsd_pkg::TAG_EXTENDED))
                    step_res = tvsd_pkg::RES_ERROR;
                else
                begin
                    tag_number_next = data_byte[3:0];
                    tag_known       = 1'b1;
                end
            end
            tvsd_pkg::PH_LEN_MARK:
            begin
                header_count_next = header_count_reg + 3'd1;
                if (data_byte < tvsd_pkg::LEN_MARK_16)
                begin
                    len_known = 1'b1;
                    len_cand  = 32'(data_byte);
                end
                else
                begin
                    ext_bytes_left_next = (data_byte == tvsd_pkg::LEN_MARK_16)
                                          ? tvsd_pkg::EXT_BYTES_16 : tvsd_pkg::EXT_BYTES_32;
                    accumulator_next    = 32'd0;
                    step_phase          = tvsd_pkg::PH_LEN_BYTES;
                end
            end
            tvsd_pkg::PH_LEN_BYTES:
            begin
                header_count_next = header_count_reg + 3'd1;
                accumulator_next  = acc_shift;
                if (ext_bytes_left_reg != 3'd0)
                    ext_bytes_left_next = ext_bytes_left_reg - 3'd1;
                if (ext_bytes_left_reg <= 3'd1)
                begin
                    len_known = 1'b1;
                    len_cand  = acc_shift;
                end
            end
            tvsd_pkg::PH_CONTENT:
            begin
                if (content_count_reg == '0)
                    first_content_byte_next = data_byte;
                // unused-bits octet of a bit string is checked before it is counted
                if (content_count_reg == '0 && tag_number_reg == tvsd_pkg::TAG_BIT_STRING &&
                    (data_byte > tvsd_pkg::MAX_UNUSED_BITS ||
                     (content_length_reg == LENGTH_BITS'(1) && data_byte != 8'd0)))
                    step_res = tvsd_pkg::RES_ERROR;
                else
                begin
                    accumulator_next   = acc_shift;
                    content_count_next = count_inc[LENGTH_BITS-1:0];
                    if (count_inc >= {1'b0, content_length_reg})
                        step_res = tvsd_pkg::RES_DONE;
                end
            end
            default:
            begin
            end
        endcase

        if (tag_known)
        begin
            if (tag_number_next == tvsd_pkg::TAG_DOUBLE ||
                tag_number_next > tvsd_pkg::TAG_OBJECT_ID)
                step_res = tvsd_pkg::RES_ERROR;
            else if (tag_number_next == tvsd_pkg::TAG_NULL)
                step_res = (raw_length_bits_next != 3'd0) ? tvsd_pkg::RES_ERROR
                                                          : tvsd_pkg::RES_DONE;
            else if (tag_number_next == tvsd_pkg::TAG_BOOLEAN)
                step_res = (raw_length_bits_next > 3'd1) ? tvsd_pkg::RES_ERROR
                                                         : tvsd_pkg::RES_DONE;
            else if (raw_length_bits_next < tvsd_pkg::RAW_LEN_EXT)
            begin
                len_known = 1'b1;
                len_cand  = 32'(raw_length_bits_next);
            end
            else
                step_phase = tvsd_pkg::PH_LEN_MARK;
        end

        if (len_known)
        begin
            if ((len_cand >> LENGTH_BITS) != 32'd0 ||
                !tvsd_pkg::length_ok(tag_number_next, len_cand))
                step_res = tvsd_pkg::RES_ERROR;
            else
            begin
                accumulator_next    = 32'd0;
                content_count_next  = '0;
                content_length_next = len_cand[LENGTH_BITS-1:0];
                if (len_cand == 32'd0)
                    step_res = tvsd_pkg::RES_DONE;
                else
                    step_phase = tvsd_pkg::PH_CONTENT;
            end
        end
    end

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            if (last_byte)
                phase_next = tvsd_pkg::PH_TAG;
            else if (step_res == tvsd_pkg::RES_NONE)
                phase_next = step_phase;
            else
                phase_next = tvsd_pkg::PH_SKIP;
        end
    end

    // Result: value finished, error found, or buffer ended mid-value
    assign emit = accept && (step_res != tvsd_pkg::RES_NONE ||
                             (last_byte && phase_reg != tvsd_pkg::PH_SKIP));

    always_comb
    begin
        raw_res.err     = (step_res != tvsd_pkg::RES_DONE);
        raw_res.tag     = tag_number_next;
        raw_res.raw_len = raw_length_bits_next;
        raw_res.hdr     = header_count_next;
        raw_res.len     = 32'(content_length_next);
        raw_res.acc     = accumulator_next;
        raw_res.fcb     = first_content_byte_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg              <= tvsd_pkg::PH_TAG;
            tag_number_reg         <= 4'd0;
            raw_length_bits_reg    <= 3'd0;
            header_count_reg       <= 3'd0;
            ext_bytes_left_reg     <= 3'd0;
            content_length_reg     <= '0;
            content_count_reg      <= '0;
            accumulator_reg        <= 32'd0;
            first_content_byte_reg <= 8'd0;
        end
        else if (accept)
        begin
            phase_reg              <= phase_next;
            tag_number_reg         <= tag_number_next;
            raw_length_bits_reg    <= raw_length_bits_next;
            header_count_reg       <= header_count_next;
            ext_bytes_left_reg     <= ext_bytes_left_next;
            content_length_reg     <= content_length_next;
            content_count_reg      <= content_count_next;
            accumulator_reg        <= accumulator_next;
            first_content_byte_reg <= first_content_byte_next;
        end
    end

`ifndef SYNTHESIS
    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_byte |=> phase_reg == tvsd_pkg::PH_TAG)
        else $error("phase not back to tag after last word");

    a_content_bound: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == tvsd_pkg::PH_CONTENT |-> content_count_reg < content_length_reg)
        else $error("content count reached length without completing");

    a_ext_pending: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == tvsd_pkg::PH_LEN_BYTES |-> ext_bytes_left_reg != 3'd0)
        else $error("extended length phase with no octets left");
`endif

endmodule

>>> rtl/tvsd_format.sv
// Maps parser state at a finished value onto the result fields.
// Depends on tvsd_pkg.
module tvsd_format (
    input  tvsd_pkg::raw_result_t raw_res,
    output tvsd_pkg::result_t     res
);

    logic [31:0] sign_mask;
    logic [31:0] len_less1;

    assign len_less1 = raw_res.len - 32'd1;

    // sign extension of a short signed value
    always_comb
    begin
        sign_mask = 32'd0;
        if (raw_res.fcb[7] && raw_res.len < 32'd4)
        begin
            case (raw_res.len[1:0])
                2'd1:    sign_mask = 32'hFFFF_FF00;
                2'd2:    sign_mask = 32'hFFFF_0000;
                2'd3:    sign_mask = 32'hFF00_0000;
                default: sign_mask = 32'd0;
            endcase
        end
    end

    always_comb
    begin
        res = '0;
        if (raw_res.err)
            res.status = 1'b1;
        else
        begin
            res.value_type     = raw_res.tag;
            res.consumed_bytes = 33'(raw_res.hdr) + 33'(raw_res.len);
            case (raw_res.tag)
                tvsd_pkg::TAG_BOOLEAN:
                    res.word_value = 32'(raw_res.raw_len);
                tvsd_pkg::TAG_UNSIGNED, tvsd_pkg::TAG_ENUMERATED,
                tvsd_pkg::TAG_REAL, tvsd_pkg::TAG_TIME:
                    res.word_value = raw_res.acc;
                tvsd_pkg::TAG_SIGNED:
                    res.word_value = raw_res.acc | sign_mask;
                tvsd_pkg::TAG_DATE:
                begin
                    res.word_value = raw_res.acc;
                    if (raw_res.fcb == tvsd_pkg::YEAR_UNSPEC)
                        res.year_unspecified = 1'b1;
                    else
                        res.date_year = tvsd_pkg::YEAR_BASE + 12'(raw_res.fcb);
                end
                tvsd_pkg::TAG_OBJECT_ID:
                begin
                    res.word_value      = raw_res.acc;
                    res.object_type     = raw_res.acc[31:22];
                    res.object_instance = raw_res.acc[21:0] & tvsd_pkg::INSTANCE_MASK;
                end
                tvsd_pkg::TAG_OCTET_STRING:
                begin
                    res.data_offset = raw_res.hdr;
                    res.data_length = raw_res.len;
                end
                tvsd_pkg::TAG_CHAR_STRING:
                begin
                    // wraps to 0 behind a seven-octet header
                    res.data_offset = raw_res.hdr + 3'd1;
                    res.data_length = len_less1;
                    res.charset     = raw_res.fcb;
                end
                tvsd_pkg::TAG_BIT_STRING:
                begin
                    res.data_offset = raw_res.hdr + 3'd1;
                    res.data_length = len_less1;
                    res.bit_count   = {len_less1, 3'b000} - 35'(raw_res.fcb);
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

>>> rtl/tvsd_out_buf.sv
// Two-entry result buffer: output register plus skid entry.
// Depends on tvsd_pkg and tvsd_out_if.
module tvsd_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tvsd_pkg::result_t push_data,
    output logic              push_ready,
    tvsd_out_if.source        result
);

    tvsd_pkg::result_t head_reg, head_next;
    tvsd_pkg::result_t skid_reg, skid_next;
    logic              head_valid_reg, head_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    logic              pop;

    assign pop        = head_valid_reg && result.ready;
    assign push_ready = !skid_valid_reg;

    always_comb
    begin
        head_next       = head_reg;
        skid_next       = skid_reg;
        head_valid_next = head_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                head_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
            else if (push)
                head_next = push_data;
            else
                head_valid_next = 1'b0;
        end
        else if (push)
        begin
            if (!head_valid_reg)
            begin
                head_next       = push_data;
                head_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    assign result.valid            = head_valid_reg;
    assign result.status           = head_reg.status;
    assign result.value_type       = head_reg.value_type;
    assign result.consumed_bytes   = head_reg.consumed_bytes;
    assign result.word_value       = head_reg.word_value;
    assign result.object_type      = head_reg.object_type;
    assign result.object_instance  = head_reg.object_instance;
    assign result.date_year        = head_reg.date_year;
    assign result.year_unspecified = head_reg.year_unspecified;
    assign result.data_offset      = head_reg.data_offset;
    assign result.data_length      = head_reg.data_length;
    assign result.charset          = head_reg.charset;
    assign result.bit_count        = head_reg.bit_count;

`ifndef SYNTHESIS
    a_skid_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> head_valid_reg)
        else $error("skid entry held with empty output register");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !skid_valid_reg)
        else $error("word pushed into full result buffer");

    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> head_valid_reg)
        else $error("pushed result not visible at output");
`endif

endmodule

>>> rtl/tagged_value_stream_decoder_core.sv
// Tagged value stream decoder, top level. One byte per cycle is accepted.
// Output: the result of the byte that ends a value is registered in the result buffer.
// Throughput: one byte every cycle; ready falls only when both entries of the
// two-entry result buffer are full.
// Reset (rst_n, async, active low): parser returns to awaiting a tag octet with
// cleared counters, and the result buffer empties. Depends on tvsd_pkg, interfaces.
module tagged_value_stream_decoder_core #(
    parameter int LENGTH_BITS = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    tvsd_in_if.sink    stream,
    tvsd_out_if.source result
);

    logic                  accept;
    logic                  emit;
    logic                  push_ready;
    tvsd_pkg::raw_result_t raw_res;
    tvsd_pkg::result_t     res;

    assign stream.ready = push_ready;
    assign accept       = stream.valid && push_ready;

    tvsd_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (stream.data_byte),
        .last_byte (stream.last_byte),
        .emit      (emit),
        .raw_res   (raw_res)
    );

    tvsd_format u_format (
        .raw_res (raw_res),
        .res     (res)
    );

    tvsd_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (emit),
        .push_data  (res),
        .push_ready (push_ready),
        .result     (result)
    );

endmodule

>>> tb/tvsd_result_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the tagged value stream decoder. It follows every accepted word,
// predicts the decoded value and compares each result word with it.
// Depends on tvsd_pkg, tvsd_in_if and tvsd_out_if.
module tvsd_result_checker #(
    parameter int LENGTH_BITS = 32
) (
    input  logic clk,
    input  logic rst_n,
    tvsd_in_if   stream,
    tvsd_out_if  result,
    output int   fail_count,
    output int   pending
);

    localparam logic [32:0] LEN_MAX = (33'd1 << LENGTH_BITS) - 33'd1;

    tvsd_pkg::phase_t  parse_phase;
    logic [7:0]        tag_num;
    logic [2:0]        len_bits;
    logic [2:0]        hdr_count;
    logic [2:0]        ext_left;
    logic [31:0]       content_len;
    logic [31:0]       content_seen;
    logic [31:0]       shift_acc;
    logic [7:0]        lead_byte;
    tvsd_pkg::result_t decoded_q[$];

    function automatic void check_field(input string name, input logic [34:0] want,
                                        input logic [34:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    // Length now fixed: range check for the type, then on to the content
    function automatic tvsd_pkg::step_res_t check_length();
        if ({1'b0, content_len} > LEN_MAX)
            return tvsd_pkg::RES_ERROR;
        case (tag_num[3:0])
            tvsd_pkg::TAG_UNSIGNED, tvsd_pkg::TAG_SIGNED, tvsd_pkg::TAG_ENUMERATED:
                if (content_len < 32'd1 || content_len > 32'd4)
                    return tvsd_pkg::RES_ERROR;
            tvsd_pkg::TAG_REAL, tvsd_pkg::TAG_DATE, tvsd_pkg::TAG_TIME,
            tvsd_pkg::TAG_OBJECT_ID:
                if (content_len != 32'd4)
                    return tvsd_pkg::RES_ERROR;
            tvsd_pkg::TAG_CHAR_STRING, tvsd_pkg::TAG_BIT_STRING:
                if (content_len == 32'd0)
                    return tvsd_pkg::RES_ERROR;
            default: ;
        endcase
        shift_acc = '0;
        content_seen = '0;
        if (content_len == 32'd0)
            return tvsd_pkg::RES_DONE;
        parse_phase = tvsd_pkg::PH_CONTENT;
        return tvsd_pkg::RES_NONE;
    endfunction

    function automatic tvsd_pkg::step_res_t check_tag();
        if (tag_num == 8'(tvsd_pkg::TAG_DOUBLE) || tag_num > 8'(tvsd_pkg::TAG_OBJECT_ID))
            return tvsd_pkg::RES_ERROR;
        if (tag_num == 8'(tvsd_pkg::TAG_NULL))
            return (len_bits != 3'd0) ? tvsd_pkg::RES_ERROR : tvsd_pkg::RES_DONE;
        if (tag_num == 8'(tvsd_pkg::TAG_BOOLEAN))
            return (len_bits > 3'd1) ? tvsd_pkg::RES_ERROR : tvsd_pkg::RES_DONE;
        if (len_bits < tvsd_pkg::RAW_LEN_EXT)
        begin
            content_len = 32'(len_bits);
            return check_length();
        end
        parse_phase = tvsd_pkg::PH_LEN_MARK;
        return tvsd_pkg::RES_NONE;
    endfunction

    function automatic tvsd_pkg::step_res_t consume_byte(input logic [7:0] b);
        case (parse_phase)
            tvsd_pkg::PH_TAG:
            begin
                tag_num = 8'(b[7:4]);
                len_bits = b[2:0];
                hdr_count = 3'd1;
                ext_left = '0;
                content_len = '0;
                content_seen = '0;
                shift_acc = '0;
                lead_byte = '0;
                // context class, or reserved length bits 6/7
                if (b[tvsd_pkg::CLASS_BIT] || b[2:0] >= 3'd6)
                    return tvsd_pkg::RES_ERROR;
                if (b[7:4] == tvsd_pkg::TAG_EXTENDED)
                begin
                    parse_phase = tvsd_pkg::PH_EXT_TAG;
                    return tvsd_pkg::RES_NONE;
                end
                return check_tag();
            end
            tvsd_pkg::PH_EXT_TAG:
            begin
                hdr_count = 3'd2;
                if (b >= 8'(tvsd_pkg::TAG_EXTENDED))
                    return tvsd_pkg::RES_ERROR;
                tag_num = b;
                return check_tag();
            end
            tvsd_pkg::PH_LEN_MARK:
            begin
                hdr_count++;
                if (b < tvsd_pkg::LEN_MARK_16)
                begin
                    content_len = 32'(b);
                    return check_length();
                end
                ext_left = (b == tvsd_pkg::LEN_MARK_16) ? tvsd_pkg::EXT_BYTES_16
                                                        : tvsd_pkg::EXT_BYTES_32;
                shift_acc = '0;
                parse_phase = tvsd_pkg::PH_LEN_BYTES;
                return tvsd_pkg::RES_NONE;
            end
            tvsd_pkg::PH_LEN_BYTES:
            begin
                hdr_count++;
                shift_acc = {shift_acc[23:0], b};
                if (ext_left != 3'd0)
                    ext_left--;
                if (ext_left != 3'd0)
                    return tvsd_pkg::RES_NONE;
                content_len = shift_acc;
                return check_length();
            end
            tvsd_pkg::PH_CONTENT:
            begin
                if (content_seen == 32'd0)
                begin
                    lead_byte = b;
                    if (tag_num == 8'(tvsd_pkg::TAG_BIT_STRING) &&
                        (b > tvsd_pkg::MAX_UNUSED_BITS || (content_len == 32'd1 && b != 8'd0)))
                        return tvsd_pkg::RES_ERROR;
                end
                shift_acc = {shift_acc[23:0], b};
                content_seen++;
                return (content_seen >= content_len) ? tvsd_pkg::RES_DONE
                                                     : tvsd_pkg::RES_NONE;
            end
            default:
                return tvsd_pkg::RES_NONE;
        endcase
    endfunction

    function automatic tvsd_pkg::result_t decoded_fields();
        tvsd_pkg::result_t r;
        r = '0;
        r.value_type = tag_num[3:0];
        r.consumed_bytes = 33'(hdr_count) + 33'(content_len);
        case (tag_num[3:0])
            tvsd_pkg::TAG_BOOLEAN:
                r.word_value = 32'(len_bits);
            tvsd_pkg::TAG_UNSIGNED, tvsd_pkg::TAG_ENUMERATED, tvsd_pkg::TAG_REAL,
            tvsd_pkg::TAG_TIME:
                r.word_value = shift_acc;
            tvsd_pkg::TAG_SIGNED:
            begin
                r.word_value = shift_acc;
                if (content_len < 32'd4 && lead_byte[7])
                    r.word_value |= 32'hFFFF_FFFF << (content_len * 8);
            end
            tvsd_pkg::TAG_DATE:
            begin
                r.word_value = shift_acc;
                if (lead_byte == tvsd_pkg::YEAR_UNSPEC)
                    r.year_unspecified = 1'b1;
                else
                    r.date_year = tvsd_pkg::YEAR_BASE + 12'(lead_byte);
            end
            tvsd_pkg::TAG_OBJECT_ID:
            begin
                r.word_value = shift_acc;
                r.object_type = shift_acc[31:22];
                r.object_instance = shift_acc[21:0] & tvsd_pkg::INSTANCE_MASK;
            end
            tvsd_pkg::TAG_OCTET_STRING:
            begin
                r.data_offset = hdr_count;
                r.data_length = content_len;
            end
            tvsd_pkg::TAG_CHAR_STRING:
            begin
                // a seven-octet header wraps the offset to zero
                r.data_offset = hdr_count + 3'd1;
                r.data_length = content_len - 32'd1;
                r.charset = lead_byte;
            end
            tvsd_pkg::TAG_BIT_STRING:
            begin
                r.data_offset = hdr_count + 3'd1;
                r.data_length = content_len - 32'd1;
                r.bit_count = (35'(content_len - 32'd1) << 3) - 35'(lead_byte);
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic void predict_byte(input logic [7:0] b, input logic fin);
        tvsd_pkg::step_res_t outcome;
        logic                in_value;
        tvsd_pkg::result_t   r;
        in_value = (parse_phase != tvsd_pkg::PH_SKIP);
        outcome = consume_byte(b);
        if (outcome == tvsd_pkg::RES_NONE)
        begin
            if (!fin)
                return;
            parse_phase = tvsd_pkg::PH_TAG;
            if (!in_value)
                return;
            // buffer ended mid-value
            outcome = tvsd_pkg::RES_ERROR;
        end
        if (outcome == tvsd_pkg::RES_ERROR)
        begin
            r = '0;
            r.status = 1'b1;
        end
        else
            r = decoded_fields();
        decoded_q.push_back(r);
        parse_phase = fin ? tvsd_pkg::PH_TAG : tvsd_pkg::PH_SKIP;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        tvsd_pkg::result_t got;
        tvsd_pkg::result_t want;
        if (!rst_n)
        begin
            parse_phase = tvsd_pkg::PH_TAG;
            tag_num = '0;
            len_bits = '0;
            hdr_count = '0;
            ext_left = '0;
            content_len = '0;
            content_seen = '0;
            shift_acc = '0;
            lead_byte = '0;
            decoded_q.delete();
            pending = 0;
            fail_count = 0;
        end
        else
        begin
            if (stream.valid && stream.ready)
                predict_byte(stream.data_byte, stream.last_byte);
            if (result.valid && result.ready)
            begin
                got.status           = result.status;
                got.value_type       = result.value_type;
                got.consumed_bytes   = result.consumed_bytes;
                got.word_value       = result.word_value;
                got.object_type      = result.object_type;
                got.object_instance  = result.object_instance;
                got.date_year        = result.date_year;
                got.year_unspecified = result.year_unspecified;
                got.data_offset      = result.data_offset;
                got.data_length      = result.data_length;
                got.charset          = result.charset;
                got.bit_count        = result.bit_count;
                if (decoded_q.size() == 0)
                begin
                    $error("result word with no decoded value waiting");
                    fail_count++;
                end
                else
                begin
                    want = decoded_q.pop_front();
                    check_field("status", 35'(want.status), 35'(got.status));
                    check_field("value_type", 35'(want.value_type), 35'(got.value_type));
                    check_field("consumed_bytes", 35'(want.consumed_bytes),
                                35'(got.consumed_bytes));
                    check_field("word_value", 35'(want.word_value), 35'(got.word_value));
                    check_field("object_type", 35'(want.object_type), 35'(got.object_type));
                    check_field("object_instance", 35'(want.object_instance),
                                35'(got.object_instance));
                    check_field("date_year", 35'(want.date_year), 35'(got.date_year));
                    check_field("year_unspecified", 35'(want.year_unspecified),
                                35'(got.year_unspecified));
                    check_field("data_offset", 35'(want.data_offset), 35'(got.data_offset));
                    check_field("data_length", 35'(want.data_length), 35'(got.data_length));
                    check_field("charset", 35'(want.charset), 35'(got.charset));
                    check_field("bit_count", want.bit_count, got.bit_count);
                end
            end
            pending = decoded_q.size();
        end
    end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// Top of the decoder testbench: clock, reset, byte-stream stimulus, result stalls,
// watchdog and verdict. Depends on tvsd_pkg, the interfaces and tvsd_result_checker.
module tb;

    localparam int LENGTH_BITS = 32;
    localparam int BYTE_TARGET = 1300;
    localparam int IDLE_LIMIT  = 4000;
    localparam logic [3:0] SIZED_TAGS [9] = '{
        tvsd_pkg::TAG_UNSIGNED, tvsd_pkg::TAG_SIGNED, tvsd_pkg::TAG_ENUMERATED,
        tvsd_pkg::TAG_REAL, tvsd_pkg::TAG_DATE, tvsd_pkg::TAG_TIME,
        tvsd_pkg::TAG_OBJECT_ID, tvsd_pkg::TAG_CHAR_STRING, tvsd_pkg::TAG_BIT_STRING};

    logic       clk;
    logic       rst_n;
    int         fail_count;
    int         pending;
    int         bytes_sent = 0;
    int         burst_left = 0;
    int         idle_cycles = 0;
    int         buffers_sent = 0;
    logic [7:0] stall_cycle = '0;
    logic [7:0] buf_q[$];

    tvsd_in_if  in_bus();
    tvsd_out_if res_bus();

    tagged_value_stream_decoder_core #(.LENGTH_BITS(LENGTH_BITS)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (in_bus),
        .result (res_bus)
    );

    tvsd_result_checker #(.LENGTH_BITS(LENGTH_BITS)) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .stream     (in_bus),
        .result     (res_bus),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result side stalls: the mode follows the top two bits of a free-running cycle counter
    always @(posedge clk)
    begin
        if (!rst_n)
            res_bus.ready <= 1'b0;
        else
        begin
            stall_cycle <= stall_cycle + 8'd1;
            case (stall_cycle[7:6])
                2'd0:    res_bus.ready <= 1'b1;
                2'd1:    res_bus.ready <= ($urandom_range(0, 1) == 1);
                2'd2:    res_bus.ready <= ($urandom_range(0, 3) == 0);
                default: res_bus.ready <= (stall_cycle[2:0] < 3'd5);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_bus.valid && in_bus.ready) || (res_bus.valid && res_bus.ready))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic fin);
        int   gap;
        logic took;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                in_bus.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        in_bus.valid     <= 1'b1;
        in_bus.data_byte <= b;
        in_bus.last_byte <= fin;
        do
        begin
            @(negedge clk);
            took = in_bus.ready;
            @(posedge clk);
        end
        while (!took);
        bytes_sent++;
    endtask

    task automatic send_buffer();
        foreach (buf_q[i])
            send_byte(buf_q[i], i == buf_q.size() - 1);
        buffers_sent++;
    endtask

    task automatic wait_results_drained();
        in_bus.valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        @(posedge clk);
    endtask

    // Tag octet, optional extended tag, and a length in any of its encodings
    task automatic push_header(input logic [3:0] tag, input logic [31:0] len);
        logic ext_tag;
        int   style;
        ext_tag = ($urandom_range(0, 5) == 0);
        style = $urandom_range(0, 3);
        if (len < 32'd5 && style != 0)
        begin
            buf_q.push_back({ext_tag ? tvsd_pkg::TAG_EXTENDED : tag, 1'b0, len[2:0]});
            if (ext_tag)
                buf_q.push_back(8'(tag));
            return;
        end
        buf_q.push_back({ext_tag ? tvsd_pkg::TAG_EXTENDED : tag, 1'b0,
                         tvsd_pkg::RAW_LEN_EXT});
        if (ext_tag)
            buf_q.push_back(8'(tag));
        if (len < 32'd254 && style < 2)
            buf_q.push_back(len[7:0]);
        else if (len < 32'h1_0000 && style < 3)
        begin
            buf_q.push_back(tvsd_pkg::LEN_MARK_16);
            buf_q.push_back(len[15:8]);
            buf_q.push_back(len[7:0]);
        end
        else
        begin
            buf_q.push_back(tvsd_pkg::LEN_MARK_32);
            buf_q.push_back(len[31:24]);
            buf_q.push_back(len[23:16]);
            buf_q.push_back(len[15:8]);
            buf_q.push_back(len[7:0]);
        end
    endtask

    task automatic push_value(input logic [3:0] tag);
        int         len;
        logic       ext_tag;
        logic [7:0] octet;
        if (tag == tvsd_pkg::TAG_NULL || tag == tvsd_pkg::TAG_BOOLEAN)
        begin
            ext_tag = ($urandom_range(0, 5) == 0);
            buf_q.push_back({ext_tag ? tvsd_pkg::TAG_EXTENDED : tag, 3'b000,
                             (tag == tvsd_pkg::TAG_BOOLEAN) ? 1'($urandom_range(0, 1))
                                                            : 1'b0});
            if (ext_tag)
                buf_q.push_back(8'(tag));
            return;
        end
        case (tag)
            tvsd_pkg::TAG_UNSIGNED, tvsd_pkg::TAG_SIGNED, tvsd_pkg::TAG_ENUMERATED:
                len = $urandom_range(1, 4);
            tvsd_pkg::TAG_OCTET_STRING:
                len = ($urandom_range(0, 79) == 0) ? $urandom_range(254, 300)
                                                   : $urandom_range(0, 10);
            tvsd_pkg::TAG_CHAR_STRING, tvsd_pkg::TAG_BIT_STRING:
                len = ($urandom_range(0, 79) == 0) ? $urandom_range(254, 300)
                                                   : $urandom_range(1, 10);
            default:
                len = 4;
        endcase
        push_header(tag, 32'(len));
        for (int i = 0; i < len; i++)
        begin
            octet = 8'($urandom());
            if (i == 0 && tag == tvsd_pkg::TAG_BIT_STRING)
                octet = (len == 1) ? 8'd0 : 8'($urandom_range(0, 7));
            if (i == 0 && tag == tvsd_pkg::TAG_DATE && $urandom_range(0, 3) == 0)
                octet = tvsd_pkg::YEAR_UNSPEC;
            buf_q.push_back(octet);
        end
    endtask

    function automatic logic [3:0] pick_valid_tag();
        logic [3:0] tag;
        tag = 4'($urandom_range(0, 11));
        if (tag >= tvsd_pkg::TAG_DOUBLE)
            tag++;
        return tag;
    endfunction

    task automatic build_random_buffer();
        int         kind;
        int         len;
        logic [3:0] tag;
        buf_q.delete();
        kind = $urandom_range(0, 99);
        if (kind < 65)
        begin
            push_value(pick_valid_tag());
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) buf_q.push_back(8'($urandom()));
        end
        else if (kind < 73)
        begin
            // cut short before the value completes
            push_value(pick_valid_tag());
            if (buf_q.size() > 1)
                repeat ($urandom_range(1, buf_q.size() - 1)) void'(buf_q.pop_back());
        end
        else if (kind < 80)
        begin
            tag = SIZED_TAGS[$urandom_range(0, 8)];
            case (tag)
                tvsd_pkg::TAG_CHAR_STRING, tvsd_pkg::TAG_BIT_STRING:
                    len = 0;
                tvsd_pkg::TAG_REAL, tvsd_pkg::TAG_DATE, tvsd_pkg::TAG_TIME,
                tvsd_pkg::TAG_OBJECT_ID:
                begin
                    len = $urandom_range(0, 7);
                    if (len == 4)
                        len = 0;
                end
                default:
                    len = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(5, 8);
            endcase
            push_header(tag, 32'(len));
            repeat ((len > 3) ? 3 : len) buf_q.push_back(8'($urandom()));
        end
        else if (kind < 85)
        begin
            // unused-bits octet out of range
            len = $urandom_range(1, 6);
            push_header(tvsd_pkg::TAG_BIT_STRING, 32'(len));
            buf_q.push_back((len == 1) ? 8'($urandom_range(1, 255))
                                       : 8'($urandom_range(8, 255)));
            repeat (len - 1) buf_q.push_back(8'($urandom()));
        end
        else if (kind < 90)
        begin
            case ($urandom_range(0, 5))
                0: buf_q.push_back({4'($urandom()), 1'b1, 3'($urandom())});
                1: buf_q.push_back({4'($urandom()), 1'b0, 3'($urandom_range(6, 7))});
                2:
                begin
                    buf_q.push_back({tvsd_pkg::TAG_EXTENDED, 1'b0, 3'($urandom_range(0, 5))});
                    buf_q.push_back(8'($urandom_range(15, 255)));
                end
                3: buf_q.push_back({tvsd_pkg::TAG_NULL, 1'b0, 3'($urandom_range(1, 5))});
                4: buf_q.push_back({tvsd_pkg::TAG_BOOLEAN, 1'b0, 3'($urandom_range(2, 5))});
                default:
                begin
                    case ($urandom_range(0, 2))
                        0:       tag = tvsd_pkg::TAG_DOUBLE;
                        1:       tag = 4'd13;
                        default: tag = 4'd14;
                    endcase
                    if ($urandom_range(0, 1) == 1)
                    begin
                        buf_q.push_back({tvsd_pkg::TAG_EXTENDED, 1'b0,
                                         3'($urandom_range(0, 5))});
                        buf_q.push_back(8'(tag));
                    end
                    else
                        buf_q.push_back({tag, 1'b0, 3'($urandom_range(0, 5))});
                end
            endcase
            repeat ($urandom_range(0, 2)) buf_q.push_back(8'($urandom()));
        end
        else if (kind < 94)
        begin
            // huge declared length, buffer ends long before it
            tag = ($urandom_range(0, 3) == 0) ? pick_valid_tag()
                                              : 4'($urandom_range(6, 8));
            if (tag == tvsd_pkg::TAG_NULL || tag == tvsd_pkg::TAG_BOOLEAN)
                tag = tvsd_pkg::TAG_OCTET_STRING;
            push_header(tag, $urandom());
            repeat ($urandom_range(0, 3)) buf_q.push_back(8'($urandom()));
        end
        else
            repeat ($urandom_range(1, 6)) buf_q.push_back(8'($urandom()));
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_bus.valid     <= 1'b0;
        in_bus.data_byte <= 8'h00;
        in_bus.last_byte <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        buf_q = '{8'h00};                             // null
        send_buffer();
        buf_q = '{8'h11};                             // boolean true
        send_buffer();
        buf_q = '{8'h24, 8'hFF, 8'hFF, 8'hFF, 8'hFF}; // largest unsigned
        send_buffer();
        buf_q = '{8'h0D};                             // context class
        send_buffer();
        buf_q = '{8'h26};                             // reserved length bits
        send_buffer();
        buf_q = '{8'hF0, 8'hFF};                      // extended tag 255
        send_buffer();
        buf_q = '{8'h31, 8'h80};                      // signed, sign-extended
        send_buffer();
        buf_q = '{8'h81, 8'h03};                      // one-octet bit string, unused bits set
        send_buffer();
        // 7-octet header before a character string: payload offset wraps to 0
        buf_q = '{8'hF5, 8'h07, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h02, 8'h00, 8'h41};
        send_buffer();
        buf_q = '{8'h44, 8'h01};                      // real cut short
        send_buffer();
        buf_q = '{8'h00, 8'h12};                      // trailing byte ignored
        send_buffer();

        while (bytes_sent < BYTE_TARGET)
        begin
            build_random_buffer();
            send_buffer();
            if (buffers_sent % 40 == 20)
                wait_results_drained();
        end

        wait_results_drained();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
